@@ rtl/core/nns_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package nns_pkg;

  // Source image size.
  localparam int IN_ROWS = 28;
  localparam int IN_COLS = 28;
  localparam int DEPTH   = IN_ROWS * IN_COLS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Field widths.
  localparam int CRD_W  = 6;
  localparam int PIX_W  = 8;
  localparam int SIZE_W = 7;
  localparam int DEN_W  = SIZE_W + 1;
  localparam int NUM_W  = 13;
  localparam int CFG_IDX_W = 2;

  // Largest output size and the reset value of both size registers.
  localparam int MAX_SIZE   = 64;
  localparam int SIZE_RESET = 28;

  // Width of a source index. Quotients never reach the larger input size.
  localparam int IN_MAX = (IN_ROWS > IN_COLS) ? IN_ROWS : IN_COLS;
  localparam int IDX_W  = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUT_ROWS = 2'd0,
    REG_OUT_COLS = 2'd1
  } nns_reg_t;

  // Operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic             op;
    logic [CRD_W-1:0] row;
    logic [CRD_W-1:0] col;
    logic [PIX_W-1:0] pixel;
  } nns_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             out_of_range;
  } nns_out_t;

  // Per-item control that travels beside the index dividers.
  typedef struct packed {
    logic              vld;
    logic              rd;
    logic              oor;
    logic              wen;
    logic [ADDR_W-1:0] waddr;
    logic [PIX_W-1:0]  pixel;
  } nns_side_t;

  // State of one axis inside the restoring divider.
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [IDX_W-1:0] quo;
  } nns_axis_t;

endpackage

`default_nettype wire

@@ rtl/core/nearest_neighbor_image_scaler.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Nearest-neighbor scaler over a 28 x 28 greyscale frame store. A write
// item (op 0) stores a pixel at a source row and column; writes outside the
// source image are dropped and no write gives a result. A read item (op 1)
// names a row and column of the scaled image (out_rows x out_cols, each
// 1..64, where 0 acts as 1 and anything above 64 acts as 64) and returns
// the source pixel nearest to that output pixel's center, ties going to
// the lower index; a coordinate outside the scaled image returns value 0
// with out_of_range set. The block takes one item every clock while
// in_stall is low. A read result passes through one input register, one
// restoring-divider stage per source index bit, an address stage, the
// memory read and the output register. A two-entry output buffer keeps
// the pipeline moving while a result waits, and in_stall rises only once
// both entries are full. The frame store has no reset and must be written
// before it is read. Size registers are written through the cfg port,
// which is always ready, and may only change while no item is in flight.
module nearest_neighbor_image_scaler (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  nns_pkg::nns_in_t              in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output nns_pkg::nns_out_t             out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nns_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nns_pkg::SIZE_W-1:0]    cfg_data
);
  import nns_pkg::*;

  logic [SIZE_W-1:0] out_rows_r;
  logic [SIZE_W-1:0] out_cols_r;
  logic [SIZE_W-1:0] eff_rows;
  logic [SIZE_W-1:0] eff_cols;

  logic      en;
  logic      accept;
  nns_side_t side_in;
  nns_axis_t row_in;
  nns_axis_t col_in;

  nns_side_t        side_q;
  logic [IDX_W-1:0] row_idx_q;
  logic [IDX_W-1:0] col_idx_q;

  logic     res_vld;
  nns_out_t res;

  logic     out_valid_r;
  logic     out_valid_nxt;
  nns_out_t out_data_r;
  nns_out_t out_data_nxt;
  logic     skid_valid_r;
  logic     skid_valid_nxt;
  nns_out_t skid_data_r;
  nns_out_t skid_data_nxt;
  logic     pop;

  // Configuration registers. Indexes past the list are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_rows_r <= SIZE_W'(SIZE_RESET);
      out_cols_r <= SIZE_W'(SIZE_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OUT_ROWS: out_rows_r <= cfg_data;
        REG_OUT_COLS: out_cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp each size into 1..64.
  always_comb begin
    if (out_rows_r == '0) begin
      eff_rows = SIZE_W'(1);
    end else if (out_rows_r > SIZE_W'(MAX_SIZE)) begin
      eff_rows = SIZE_W'(MAX_SIZE);
    end else begin
      eff_rows = out_rows_r;
    end
    if (out_cols_r == '0) begin
      eff_cols = SIZE_W'(1);
    end else if (out_cols_r > SIZE_W'(MAX_SIZE)) begin
      eff_cols = SIZE_W'(MAX_SIZE);
    end else begin
      eff_cols = out_cols_r;
    end
  end

  // The whole pipeline moves together; it only halts when the output
  // buffer is full, which is a registered condition.
  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !in_stall;

  // Set up both divisions: index = ((2j+1)*IN - 1) / (2*OUT).
  always_comb begin
    side_in.vld   = accept;
    side_in.rd    = in_item.op;
    side_in.oor   = (SIZE_W'(in_item.row) >= eff_rows) ||
                    (SIZE_W'(in_item.col) >= eff_cols);
    side_in.wen   = (SIZE_W'(in_item.row) < SIZE_W'(IN_ROWS)) &&
                    (SIZE_W'(in_item.col) < SIZE_W'(IN_COLS));
    side_in.waddr = ADDR_W'(in_item.row) * ADDR_W'(IN_COLS) + ADDR_W'(in_item.col);
    side_in.pixel = in_item.pixel;

    row_in.rem = NUM_W'({in_item.row, 1'b1}) * NUM_W'(IN_ROWS) - NUM_W'(1);
    row_in.den = {eff_rows, 1'b0};
    row_in.quo = '0;
    col_in.rem = NUM_W'({in_item.col, 1'b1}) * NUM_W'(IN_COLS) - NUM_W'(1);
    col_in.den = {eff_cols, 1'b0};
    col_in.quo = '0;
  end

  nns_index_pipe u_index_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .side_i    (side_in),
    .row_i     (row_in),
    .col_i     (col_in),
    .side_o    (side_q),
    .row_idx_o (row_idx_q),
    .col_idx_o (col_idx_q)
  );

  nns_frame_mem u_frame_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .side_i    (side_q),
    .row_idx_i (row_idx_q),
    .col_idx_i (col_idx_q),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  // Output register with a skid entry behind it.
  assign pop = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (out_valid_r && !pop) begin
      if (res_vld) begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res;
      end
    end else begin
      out_valid_nxt = res_vld;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_data_r;

endmodule

`default_nettype wire

@@ rtl/core/nns_index_pipe.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring division for both axes, one quotient bit per stage.
module nns_index_pipe (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  nns_pkg::nns_side_t      side_i,
  input  nns_pkg::nns_axis_t      row_i,
  input  nns_pkg::nns_axis_t      col_i,
  output nns_pkg::nns_side_t      side_o,
  output logic [nns_pkg::IDX_W-1:0] row_idx_o,
  output logic [nns_pkg::IDX_W-1:0] col_idx_o
);
  import nns_pkg::*;

  localparam int TW = NUM_W + IDX_W;

  nns_side_t side_r [0:IDX_W];
  nns_axis_t row_r  [0:IDX_W];
  nns_axis_t col_r  [0:IDX_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r[0].vld <= 1'b0;
    end else if (en) begin
      side_r[0].vld <= side_i.vld;
    end
    if (en) begin
      side_r[0].rd    <= side_i.rd;
      side_r[0].oor   <= side_i.oor;
      side_r[0].wen   <= side_i.wen;
      side_r[0].waddr <= side_i.waddr;
      side_r[0].pixel <= side_i.pixel;
      row_r[0]        <= row_i;
      col_r[0]        <= col_i;
    end
  end

  for (genvar s = 0; s < IDX_W; s++) begin : g_stage
    localparam int K = IDX_W - 1 - s;

    nns_axis_t row_nxt;
    nns_axis_t col_nxt;
    logic [TW-1:0] row_trial;
    logic [TW-1:0] col_trial;

    always_comb begin
      row_nxt   = row_r[s];
      col_nxt   = col_r[s];
      row_trial = TW'(row_r[s].den) << K;
      col_trial = TW'(col_r[s].den) << K;
      if (TW'(row_r[s].rem) >= row_trial) begin
        row_nxt.rem    = row_r[s].rem - row_trial[NUM_W-1:0];
        row_nxt.quo[K] = 1'b1;
      end
      if (TW'(col_r[s].rem) >= col_trial) begin
        col_nxt.rem    = col_r[s].rem - col_trial[NUM_W-1:0];
        col_nxt.quo[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[s+1].vld <= 1'b0;
      end else if (en) begin
        side_r[s+1].vld <= side_r[s].vld;
      end
      if (en) begin
        side_r[s+1].rd    <= side_r[s].rd;
        side_r[s+1].oor   <= side_r[s].oor;
        side_r[s+1].wen   <= side_r[s].wen;
        side_r[s+1].waddr <= side_r[s].waddr;
        side_r[s+1].pixel <= side_r[s].pixel;
        row_r[s+1]        <= row_nxt;
        col_r[s+1]        <= col_nxt;
      end
    end
  end

  assign side_o    = side_r[IDX_W];
  assign row_idx_o = row_r[IDX_W].quo;
  assign col_idx_o = col_r[IDX_W].quo;

endmodule

`default_nettype wire

@@ rtl/core/nns_frame_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Address stage and frame store. Writes and reads reach the memory in item
// order at the same stage, so no forwarding is needed.
module nns_frame_mem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  nns_pkg::nns_side_t        side_i,
  input  logic [nns_pkg::IDX_W-1:0] row_idx_i,
  input  logic [nns_pkg::IDX_W-1:0] col_idx_i,
  output logic                      res_vld_o,
  output nns_pkg::nns_out_t         res_o
);
  import nns_pkg::*;

  logic [PIX_W-1:0] mem [0:DEPTH-1];

  nns_side_t         side_a_r;
  logic [ADDR_W-1:0] addr_a_r;
  logic [ADDR_W-1:0] addr_a_nxt;
  logic              vld_b_r;
  logic              rd_b_r;
  logic              oor_b_r;
  logic [PIX_W-1:0]  rdata_b_r;

  always_comb begin
    if (side_i.rd == OP_READ) begin
      addr_a_nxt = ADDR_W'(row_idx_i) * ADDR_W'(IN_COLS) + ADDR_W'(col_idx_i);
    end else begin
      addr_a_nxt = side_i.waddr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_a_r.vld <= 1'b0;
      vld_b_r      <= 1'b0;
    end else if (en) begin
      side_a_r.vld <= side_i.vld;
      vld_b_r      <= side_a_r.vld;
    end
    if (en) begin
      side_a_r.rd    <= side_i.rd;
      side_a_r.oor   <= side_i.oor;
      side_a_r.wen   <= side_i.wen;
      side_a_r.waddr <= side_i.waddr;
      side_a_r.pixel <= side_i.pixel;
      addr_a_r       <= addr_a_nxt;
      rd_b_r         <= side_a_r.rd;
      oor_b_r        <= side_a_r.oor;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (side_a_r.vld && side_a_r.rd == OP_WRITE && side_a_r.wen) begin
        mem[addr_a_r] <= side_a_r.pixel;
      end
      rdata_b_r <= mem[addr_a_r];
    end
  end

  assign res_vld_o          = vld_b_r && (rd_b_r == OP_READ);
  assign res_o.value        = oor_b_r ? '0 : rdata_b_r;
  assign res_o.out_of_range = oor_b_r;

endmodule

`default_nettype wire
